FILE: hdl/hrpa_pkg.sv
// ----------------------------------------------------------------------------
// hrpa_pkg
// Shared types, codes and helpers for the hex record page assembler.
// ----------------------------------------------------------------------------
package hrpa_pkg;

  localparam int PAGE_BYTES_DEF = 128;

  localparam logic [9:0] DATA_START = 10'd9;
  localparam logic [9:0] POS_LEN    = 10'd2;
  localparam logic [9:0] POS_KIND   = 10'd8;
  localparam logic [7:0] FILL_BYTE  = 8'hFF;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] REC_DATA   = 8'h00;
  localparam logic [7:0] REC_EOF    = 8'h01;

  typedef enum logic [1:0] {
    ACT_FEED = 2'd0,
    ACT_READ = 2'd1,
    ACT_ACK  = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    RD_ZERO = 2'd0,
    RD_MEM  = 2'd1,
    RD_FILL = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] nib;
  } hex_dec_t;

  function automatic hex_dec_t hex_decode(input logic [7:0] c);
    hex_dec_t d;
    d.bad = 1'b0;
    d.nib = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.nib = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d.nib = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d.nib = 4'(c - 8'h57);
    end else begin
      d.bad = 1'b1;
    end
    return d;
  endfunction

endpackage

FILE: hdl/hrpa_if.sv
// ----------------------------------------------------------------------------
// hrpa_in_if / hrpa_out_if
// Valid/ready channels carrying input words and result words.
// ----------------------------------------------------------------------------
interface hrpa_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] char_in;
  logic [6:0] read_index;

  modport source (output valid, action, char_in, read_index, input ready);
  modport sink   (input valid, action, char_in, read_index, output ready);
endinterface

interface hrpa_out_if;
  logic        valid;
  logic        ready;
  logic        page_ready;
  logic [15:0] page_address;
  logic [7:0]  read_byte;
  logic        file_ended;
  logic        bad_digit;

  modport source (output valid, page_ready, page_address, read_byte, file_ended, bad_digit,
                  input ready);
  modport sink   (input valid, page_ready, page_address, read_byte, file_ended, bad_digit,
                  output ready);
endinterface

FILE: hdl/hex_record_page_assembler_top.sv
// ----------------------------------------------------------------------------
// hex_record_page_assembler_top
// Intel HEX text to page buffer assembler with byte readback.
// ----------------------------------------------------------------------------
// One input word per clock unless the output stalls: feed a character, read a
// page byte, or acknowledge a page. Every word yields one result word in the
// cycle after it is accepted; the input is ready whenever the result register
// is empty or being drained, so sustained rate is one word per cycle. The page
// buffer is a PAGE_BYTES x 8 memory with one write and one registered read
// per cycle. End-of-file padding is tracked by a boundary register instead of
// a sweep, so there is no clearing pass after reset.
module hex_record_page_assembler_top #(
  parameter int PAGE_BYTES = hrpa_pkg::PAGE_BYTES_DEF
) (
  input logic          clk,
  input logic          rst_n,
  hrpa_in_if.sink      in_ch,
  hrpa_out_if.source   out_ch
);

  localparam int AW = $clog2(PAGE_BYTES);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] PAGE_FULL = CW'(PAGE_BYTES);
  localparam logic [8:0]    PAGE_END  = 9'(PAGE_BYTES);
  localparam logic [15:0]   ADDR_STEP = 16'(PAGE_BYTES / 2);

  logic [7:0]     mem [PAGE_BYTES];
  logic [7:0]     mem_q_r;

  logic [AW-1:0]  fill_r, fill_nxt;
  logic [AW-1:0]  pad_from_r, pad_from_nxt;
  logic [15:0]    addr_r, addr_nxt;
  logic           first_r, first_nxt;
  logic           ready_r, ready_nxt;
  logic           ended_r, ended_nxt;
  logic [9:0]     pos_r, pos_nxt;
  logic [3:0]     hi_r, hi_nxt;
  logic [7:0]     len_r, len_nxt;
  logic [7:0]     kind_r, kind_nxt;
  logic           out_valid_r;
  logic           bad_r, bad_nxt;
  hrpa_pkg::rd_sel_t rd_sel_r, rd_sel_nxt;

  logic           acc;
  logic           feed;
  logic           in_rec;
  logic           is_colon;
  hrpa_pkg::hex_dec_t dec;
  logic [7:0]     byte_v;
  logic [9:0]     len_lim;
  logic [9:0]     rec_last;
  logic           take;
  logic           emit;
  logic [CW-1:0]  fill_inc;
  logic           wr_en;
  logic           rd_en;
  logic [8:0]     idx_ext;
  hrpa_pkg::action_t act;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;
  assign act         = hrpa_pkg::action_t'(in_ch.action);

  assign feed     = acc && (act == hrpa_pkg::ACT_FEED) && !ended_r;
  assign is_colon = (in_ch.char_in == hrpa_pkg::CHAR_COLON);
  assign in_rec   = (pos_r != 10'd0);
  assign dec      = hrpa_pkg::hex_decode(in_ch.char_in);
  assign byte_v   = pos_r[0] ? 8'h00 : {hi_r, dec.nib};
  assign len_lim  = hrpa_pkg::DATA_START + {1'b0, len_r, 1'b0};
  assign rec_last = len_lim + 10'd1;
  assign take     = (pos_r > hrpa_pkg::DATA_START) && !pos_r[0] && (pos_r < len_lim)
                    && (kind_r == hrpa_pkg::REC_DATA);
  assign fill_inc = {1'b0, fill_r} + CW'(1);
  assign idx_ext  = 9'(in_ch.read_index);

  always_comb begin
    fill_nxt     = fill_r;
    pad_from_nxt = pad_from_r;
    first_nxt    = first_r;
    ready_nxt    = ready_r;
    ended_nxt    = ended_r;
    pos_nxt      = pos_r;
    hi_nxt       = hi_r;
    len_nxt      = len_r;
    kind_nxt     = kind_r;
    emit         = 1'b0;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    bad_nxt      = 1'b0;
    rd_sel_nxt   = hrpa_pkg::RD_ZERO;

    if (feed) begin
      if (is_colon) begin
        pos_nxt = 10'd1;
      end else if (in_rec) begin
        bad_nxt = dec.bad;
        if (pos_r[0]) begin
          hi_nxt = dec.nib;
        end
        if (pos_r == hrpa_pkg::POS_LEN) begin
          len_nxt = byte_v;
        end
        if (pos_r == hrpa_pkg::POS_KIND) begin
          kind_nxt = byte_v;
        end
        if (pos_r == hrpa_pkg::POS_KIND && byte_v == hrpa_pkg::REC_EOF) begin
          pad_from_nxt = fill_r;
          fill_nxt     = '0;
          emit         = 1'b1;
          ended_nxt    = 1'b1;
          pos_nxt      = 10'd0;
        end else begin
          if (take) begin
            wr_en = 1'b1;
            if (fill_inc == PAGE_FULL) begin
              fill_nxt = '0;
              emit     = 1'b1;
            end else begin
              fill_nxt = fill_inc[AW-1:0];
            end
          end
          if (pos_r >= hrpa_pkg::POS_KIND && pos_r >= rec_last) begin
            pos_nxt = 10'd0;
          end else begin
            pos_nxt = pos_r + 10'd1;
          end
        end
      end
    end

    if (acc && act == hrpa_pkg::ACT_READ) begin
      priority if (idx_ext >= PAGE_END) begin
        rd_sel_nxt = hrpa_pkg::RD_FILL;
      end else if (ended_r && idx_ext >= 9'(pad_from_r)) begin
        rd_sel_nxt = hrpa_pkg::RD_FILL;
      end else begin
        rd_sel_nxt = hrpa_pkg::RD_MEM;
        rd_en      = 1'b1;
      end
    end

    if (acc && act == hrpa_pkg::ACT_ACK) begin
      ready_nxt = 1'b0;
    end

    addr_nxt = addr_r;
    if (emit) begin
      if (!first_r) begin
        addr_nxt = addr_r + ADDR_STEP;
      end
      first_nxt = 1'b0;
      ready_nxt = 1'b1;
    end
  end

  // page buffer
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill_r] <= byte_v;
    end
    if (rd_en) begin
      mem_q_r <= mem[idx_ext[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      addr_r      <= 16'd0;
      first_r     <= 1'b1;
      ready_r     <= 1'b0;
      ended_r     <= 1'b0;
      pos_r       <= 10'd0;
      hi_r        <= 4'd0;
      len_r       <= 8'd0;
      kind_r      <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r   <= fill_nxt;
      addr_r   <= addr_nxt;
      first_r  <= first_nxt;
      ready_r  <= ready_nxt;
      ended_r  <= ended_nxt;
      pos_r    <= pos_nxt;
      hi_r     <= hi_nxt;
      len_r    <= len_nxt;
      kind_r   <= kind_nxt;
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pad_from_r <= pad_from_nxt;
    if (acc) begin
      bad_r    <= bad_nxt;
      rd_sel_r <= rd_sel_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.page_ready   = ready_r;
  assign out_ch.page_address = addr_r;
  assign out_ch.file_ended   = ended_r;
  assign out_ch.bad_digit    = bad_r;

  always_comb begin
    unique case (rd_sel_r)
      hrpa_pkg::RD_MEM:  out_ch.read_byte = mem_q_r;
      hrpa_pkg::RD_FILL: out_ch.read_byte = hrpa_pkg::FILL_BYTE;
      default:           out_ch.read_byte = 8'h00;
    endcase
  end

  a_eof_raises_ready: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ended_r) |-> ready_r)
    else $error("end of file without page_ready");

  a_ended_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ended_r |-> (pos_r == 10'd0 && fill_r == '0))
    else $error("parser active after end of file");

  a_emit_clears_first: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ready_r) |-> !first_r)
    else $error("page emitted with first page still pending");

  a_addr_moves_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (addr_r != $past(addr_r)) |-> (ready_r && !$past(first_r)))
    else $error("page address changed without a page");

endmodule
